// ===== rtl/jss_pkg.sv =====
// Shared types, constants and register codes of the Jacobi stencil sweep block.
package jss_pkg;

  localparam int DATA_W          = 32;
  localparam int RES_W           = 64;
  localparam int ROW_W           = 16;
  localparam int COL_CFG_W       = 11;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 3;
  localparam int MIN_DIM         = 3;
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [ROW_W-1:0]     ROW_COUNT_RESET = 16'd64;
  localparam logic [COL_CFG_W-1:0] COL_COUNT_RESET = 11'd65;

  typedef enum logic [0:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } jss_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row_count;
    logic [COL_CFG_W-1:0] col_count;
  } jss_cfg_t;

  typedef struct packed {
    logic emit;
    logic border;
    logic last;
    logic clear;
  } jss_tag_t;

  typedef struct packed {
    logic [DATA_W-1:0] center;
    logic [DATA_W-1:0] up;
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] src;
    jss_tag_t          tag;
  } jss_work_t;

endpackage

// ===== rtl/jss_if.sv =====
// Valid/ready channel interfaces for the cell input and the result output.
interface jss_in_if;
  import jss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] t_value;
  logic signed [DATA_W-1:0] b_value;
  logic                     sweep_start;

  modport source (output valid, output t_value, output b_value, output sweep_start,
                  input ready);
  modport sink   (input valid, input t_value, input b_value, input sweep_start,
                  output ready);
endinterface

interface jss_out_if;
  import jss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] new_value;
  logic [RES_W-1:0]         residual_sum;
  logic                     sweep_last;

  modport source (output valid, output new_value, output residual_sum, output sweep_last,
                  input ready);
  modport sink   (input valid, input new_value, input residual_sum, input sweep_last,
                  output ready);
endinterface

// ===== rtl/jss_front.sv =====
// Front end: grid position tracking, row buffers and classification of each cell.
module jss_front #(
  parameter int  MAX_COLUMNS = jss_pkg::DEF_MAX_COLUMNS,
  parameter int  QUEUE_DEPTH = jss_pkg::DEF_QUEUE_DEPTH,
  localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  jss_in_if.sink             in_ch,
  input  jss_pkg::jss_cfg_t  cfg,
  input  logic [LVL_W-1:0]   q_level,
  output logic               push,
  output jss_pkg::jss_work_t push_data
);
  import jss_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int CW    = (CNT_W > COL_CFG_W) ? CNT_W : COL_CFG_W;

  logic [DATA_W-1:0] mid_mem [MAX_COLUMNS];
  logic [DATA_W-1:0] up_mem  [MAX_COLUMNS];
  logic [DATA_W-1:0] src_mem [MAX_COLUMNS];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DATA_W-1:0] left_r;
  logic [COL_W-1:0] up_addr_r;
  logic             s1_valid_r;
  jss_work_t        work_r;

  logic [CW-1:0]    cols_eff;
  logic [ROW_W-1:0] rows_eff;
  logic             restart;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W-1:0] right_addr;
  logic             col_last;
  logic             row_last;
  logic             accept;
  logic             up_bypass;
  jss_tag_t         tag_nxt;

  // Effective grid size after the limits: columns between MIN_DIM and MAX_COLUMNS, rows at least MIN_DIM.
  always_comb begin
    if (CW'(cfg.col_count) < CW'(MIN_DIM)) begin
      cols_eff = CW'(MIN_DIM);
    end else if (CW'(cfg.col_count) > CW'(MAX_COLUMNS)) begin
      cols_eff = CW'(MAX_COLUMNS);
    end else begin
      cols_eff = CW'(cfg.col_count);
    end
    if (cfg.row_count < ROW_W'(MIN_DIM)) begin
      rows_eff = ROW_W'(MIN_DIM);
    end else begin
      rows_eff = cfg.row_count;
    end
  end

  always_comb begin
    restart = in_ch.sweep_start || (CW'(col_r) >= cols_eff) || (row_r >= rows_eff);
    col_cur = restart ? '0 : col_r;
    row_cur = restart ? '0 : row_r;
    col_last = (CW'(col_cur) == cols_eff - CW'(1));
    row_last = (row_cur == rows_eff - ROW_W'(1));
    right_addr = (col_cur == COL_W'(MAX_COLUMNS - 1)) ? '0 : col_cur + COL_W'(1);

    tag_nxt.emit   = (row_cur != '0);
    tag_nxt.border = (row_cur == ROW_W'(1)) || (col_cur == '0) || col_last;
    tag_nxt.last   = row_last && col_last;
    tag_nxt.clear  = (row_cur == '0) && (col_cur == '0);

    if (col_last) begin
      col_nxt = '0;
      row_nxt = row_last ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_nxt = col_cur + COL_W'(1);
      row_nxt = row_cur;
    end
  end

  // The cell registered last cycle still owes its write into the upper row
  // buffer; a read of the same column must see it.
  assign up_bypass = s1_valid_r && (up_addr_r == col_cur);

  assign in_ch.ready = ((LVL_W + 1)'(q_level) + (LVL_W + 1)'(s1_valid_r))
                       < (LVL_W + 1)'(QUEUE_DEPTH);
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      left_r     <= '0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (s1_valid_r) begin
        left_r <= work_r.center;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_mem[col_cur] <= in_ch.t_value;
      src_mem[col_cur] <= in_ch.b_value;
    end
    if (s1_valid_r) begin
      up_mem[up_addr_r] <= work_r.center;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_r.center <= mid_mem[col_cur];
      work_r.right  <= mid_mem[right_addr];
      work_r.up     <= up_bypass ? work_r.center : up_mem[col_cur];
      work_r.src    <= src_mem[col_cur];
      work_r.left   <= s1_valid_r ? work_r.center : left_r;
      work_r.t      <= in_ch.t_value;
      work_r.tag    <= tag_nxt;
      up_addr_r     <= col_cur;
    end
  end

  assign push      = s1_valid_r;
  assign push_data = work_r;

endmodule

// ===== rtl/jss_queue.sv =====
// Short FIFO that carries classified cells from the front end to the arithmetic back end.
module jss_queue #(
  parameter int  DEPTH = jss_pkg::DEF_QUEUE_DEPTH,
  localparam int LVL_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jss_pkg::jss_work_t push_data,
  input  logic               pop,
  output logic               q_valid,
  output jss_pkg::jss_work_t q_data,
  output logic [LVL_W-1:0]   level
);
  import jss_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  jss_work_t        store [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0] level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= push_data;
    end
  end

  assign q_valid = (level_r != '0);
  assign q_data  = store[rd_ptr_r];
  assign level   = level_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (level_r != LVL_W'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (level_r != '0))
    else $error("queue read while empty");

  a_level_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (level_r == $past(level_r) + LVL_W'(1)))
    else $error("queue level did not follow a lone write");

endmodule

// ===== rtl/jss_back.sv =====
// Back end: stencil update, saturation, squared residual and running total.
module jss_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  jss_pkg::jss_work_t q_data,
  output logic               pop,
  jss_out_if.source          out_ch
);
  import jss_pkg::*;

  logic en;

  // Stage 1: neighbour sum.
  logic              v1_r;
  logic [33:0]       sum_r, sum_nxt;
  logic [DATA_W-1:0] src1_r, center1_r;
  jss_tag_t          tag1_r;

  // Stage 2: update and residual.
  logic              v2_r;
  logic [32:0]       upd_r, upd_nxt;
  logic [33:0]       diff_r, diff_nxt;
  logic [DATA_W-1:0] center2_r;
  jss_tag_t          tag2_r;
  logic [DATA_W-1:0] quarter;

  // Stage 3: magnitude and saturated result.
  logic              v3_r;
  logic              big_r, big_nxt;
  logic [DATA_W-1:0] mag_lo_r, mag_lo_nxt;
  logic [DATA_W-1:0] nv3_r, nv_nxt;
  logic [33:0]       mag;
  jss_tag_t          tag3_r;

  // Stage 4: square.
  logic              v4_r;
  logic [RES_W-1:0]  sq_r, sq_nxt;
  logic [DATA_W-1:0] nv4_r;
  jss_tag_t          tag4_r;

  // Output register and total.
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic [RES_W-1:0]  out_sum_r;
  logic              out_last_r;
  logic [RES_W-1:0]  total_r, total_nxt;
  logic [RES_W:0]    acc;

  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && q_valid;

  always_comb begin
    sum_nxt = {{2{q_data.up[31]}}, q_data.up} + {{2{q_data.t[31]}}, q_data.t}
            + {{2{q_data.left[31]}}, q_data.left} + {{2{q_data.right[31]}}, q_data.right};

    // Arithmetic shift right by two rounds towards minus infinity.
    quarter  = sum_r[33:2];
    upd_nxt  = {quarter[31], quarter} + {src1_r[31], src1_r};
    diff_nxt = {{2{center1_r[31]}}, center1_r} - {{2{quarter[31]}}, quarter}
             - {{2{src1_r[31]}}, src1_r};

    mag        = diff_r[33] ? (34'd0 - diff_r) : diff_r;
    big_nxt    = |mag[33:32];
    mag_lo_nxt = mag[31:0];
    if (tag2_r.border) begin
      nv_nxt = center2_r;
    end else if (upd_r[32:31] == 2'b01) begin
      nv_nxt = {1'b0, {(DATA_W - 1){1'b1}}};
    end else if (upd_r[32:31] == 2'b10) begin
      nv_nxt = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      nv_nxt = upd_r[31:0];
    end

    sq_nxt = big_r ? {RES_W{1'b1}} : RES_W'(mag_lo_r) * RES_W'(mag_lo_r);

    acc = {1'b0, total_r} + {1'b0, sq_r};
    if (tag4_r.clear) begin
      total_nxt = '0;
    end else if (tag4_r.emit && !tag4_r.border) begin
      total_nxt = acc[RES_W] ? {RES_W{1'b1}} : acc[RES_W-1:0];
    end else begin
      total_nxt = total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else if (en) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r && tag4_r.emit;
      if (v4_r) begin
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r       <= sum_nxt;
      src1_r      <= q_data.src;
      center1_r   <= q_data.center;
      tag1_r      <= q_data.tag;
      upd_r       <= upd_nxt;
      diff_r      <= diff_nxt;
      center2_r   <= center1_r;
      tag2_r      <= tag1_r;
      big_r       <= big_nxt;
      mag_lo_r    <= mag_lo_nxt;
      nv3_r       <= nv_nxt;
      tag3_r      <= tag2_r;
      sq_r        <= sq_nxt;
      nv4_r       <= nv3_r;
      tag4_r      <= tag3_r;
      out_value_r <= nv4_r;
      out_sum_r   <= total_nxt;
      out_last_r  <= tag4_r.last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.new_value    = out_value_r;
  assign out_ch.residual_sum = out_sum_r;
  assign out_ch.sweep_last   = out_last_r;

endmodule

// ===== rtl/jacobi_stencil_sweep_top.sv =====
// Top level of the streaming Jacobi five-point stencil sweep with its register port.
//
// Cells of one grid arrive in raster order over in_ch, one transfer per cell, each
// carrying the old value and source term in signed Q8.24; the block takes a cell in
// every clock cycle while the result side keeps up. From the second grid row on, each
// cell yields one result on out_ch: the updated value of the cell directly above it,
// a quarter of the neighbour sum (rounded down) plus the source term, saturated to
// 32 bits, with boundary cells passed through unchanged. Each result also carries the
// running saturated sum of squared residuals over interior cells (Q16.48), and the
// result for the last interior row's final column raises sweep_last. The figure of one
// cell per cycle is set by the three row buffers of MAX_COLUMNS words in the front
// end, which are each written once and read once per cell (the middle row buffer is
// read at two columns), and by the single 32x32 multiplier of the back end, which is
// fully pipelined. On its way to a result a cell passes the row buffer read register,
// the queue between front and back, four arithmetic stages and the output register.
// The row buffers need no clearing after reset; an entry not yet written by the sweep
// is read only for cells whose result is not emitted or is a passed-through boundary
// cell. row_count (address 0) and col_count (address 4) may be written only while no
// cell is in flight; pready is always high and reads return the registers.
module jacobi_stencil_sweep_top #(
  parameter int MAX_COLUMNS = jss_pkg::DEF_MAX_COLUMNS,
  parameter int QUEUE_DEPTH = jss_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  jss_in_if.sink                          in_ch,
  jss_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jss_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [jss_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [jss_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import jss_pkg::*;

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic [ROW_W-1:0]     row_count_r;
  logic [COL_CFG_W-1:0] col_count_r;
  jss_reg_t             reg_idx;
  logic                 cfg_write;
  jss_cfg_t             cfg;

  logic             push;
  jss_work_t        push_data;
  logic             pop;
  logic             q_valid;
  jss_work_t        q_data;
  logic [LVL_W-1:0] q_level;

  // Registers sit on word addresses; the byte offset bits are ignored, so each
  // register also answers on the three byte addresses above it.
  assign reg_idx   = jss_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RESET;
      col_count_r <= COL_COUNT_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_ROW_COUNT: row_count_r <= pwdata[ROW_W-1:0];
        REG_COL_COUNT: col_count_r <= pwdata[COL_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_COUNT: prdata = {{(APB_DATA_W - ROW_W){1'b0}}, row_count_r};
      REG_COL_COUNT: prdata = {{(APB_DATA_W - COL_CFG_W){1'b0}}, col_count_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.row_count = row_count_r;
  assign cfg.col_count = col_count_r;

  // Front end: position, row buffers and classification of every cell. It only
  // takes a cell when the queue is sure to have room for it.
  jss_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .q_level   (q_level),
    .push      (push),
    .push_data (push_data)
  );

  // The queue lets the front keep taking cells while the back end is held by a
  // stalled output.
  jss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .level     (q_level)
  );

  // Back end: arithmetic pipeline, residual total and the output register.
  jss_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
